### rtl/spid_ack_pkg.sv
package spid_ack_pkg;

    // config port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_WHEEL_BASE = 3'd3;
    localparam logic [2:0] REG_PERIOD_DT  = 3'd4;
    localparam logic [2:0] REG_RATE_HZ    = 3'd5;

    localparam logic [15:0] RST_GAIN_P     = 16'd8192;
    localparam logic [15:0] RST_GAIN_I     = 16'd410;
    localparam logic [15:0] RST_GAIN_D     = 16'd410;
    localparam logic [11:0] RST_WHEEL_BASE = 12'd768;
    localparam logic [15:0] RST_PERIOD_DT  = 16'd655;
    localparam logic [9:0]  RST_RATE_HZ    = 10'd100;

    // datapath widths
    localparam int ERR_W   = 17;
    localparam int DIF_W   = 18;
    localparam int DRV_W   = 28;
    localparam int INT_W   = 40;
    localparam int MULA_W  = 29;
    localparam int MULB_W  = 17;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int ACC_W   = 62;
    localparam int CRD_W   = 31;
    localparam int Z_W     = 18;
    localparam int ATAN_W  = 16;
    localparam int STEP_W  = 5;
    localparam int MOP_W   = 3;
    localparam int ATAN_N  = 20;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(6);

    // Q.36 rounding constant, half of one Q.8 lsb
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'h0000_0000_0800_0000);

    localparam logic signed [INT_W-1:0] INTEG_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INTEG_MIN = {1'b1, {(INT_W-1){1'b0}}};

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [11:0] wheel_base;
        logic [15:0] period_dt;
        logic [9:0]  rate_hz;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CINIT,
        ST_CORDIC,
        ST_OUT
    } t_state;

    typedef enum logic [MOP_W-1:0] {
        MUL_WB,
        MUL_EDT,
        MUL_DRATE,
        MUL_GP,
        MUL_GILO,
        MUL_GIHI,
        MUL_GD
    } t_mul_op;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        t_mul_op           mul_op;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step_idx;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/spid_ack_if.sv
interface spid_ack_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] commanded_speed;
    logic signed [15:0] commanded_yaw_rate;
    logic signed [15:0] measured_speed;

    modport source (
        output valid, commanded_speed, commanded_yaw_rate, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, commanded_speed, commanded_yaw_rate, measured_speed,
        output ready
    );
endinterface

interface spid_ack_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_command;
    logic signed [15:0] steering_command;
    logic               drive_saturated;

    modport source (
        output valid, drive_command, steering_command, drive_saturated,
        input  ready
    );
    modport sink (
        input  valid, drive_command, steering_command, drive_saturated,
        output ready
    );
endinterface

### rtl/speed_pid_with_ackermann_steering_top.sv
// Channel  Dir  Handshake      Payload                                              Role
// i_cmd    in   valid/ready    commanded_speed, commanded_yaw_rate, measured_speed  period
// o_res    out  valid/ready    drive_command, steering_command, drive_saturated     result
// apb      in   psel/penable   paddr, pwdata, pwrite -> prdata, pready              registers
//
// Each request runs through the accept cycle, the products on the shared 29x17 multiplier,
// the CORDIC load cycle, CORDIC_STEPS iterations and the result cycle.
// A request is taken only while the sequencer is idle; the result sits in an output
// register, so a new request is taken while the previous result waits.
// A stalled output holds the sequencer in its last cycle until the register frees.
// Synchronous active-low reset clears the loop state (previous error, integral) and
// loads the register defaults.
module speed_pid_with_ackermann_steering_top
    import spid_ack_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spid_ack_in_if.sink       i_cmd,
    spid_ack_out_if.source    o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg s_cfg;
    t_cmd s_cmd;
    t_sts s_sts;
    logic s_in_ready;

    spid_ack_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    spid_ack_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (s_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    spid_ack_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .i_cfg       (s_cfg),
        .i_cs        (i_cmd.commanded_speed),
        .i_yaw       (i_cmd.commanded_yaw_rate),
        .i_ms        (i_cmd.measured_speed),
        .i_out_ready (o_res.ready),
        .o_sts       (s_sts),
        .o_out_valid (o_res.valid),
        .o_drive     (o_res.drive_command),
        .o_steer     (o_res.steering_command),
        .o_sat       (o_res.drive_saturated)
    );

    assign i_cmd.ready = s_in_ready;

endmodule

### rtl/spid_ack_regs.sv
module spid_ack_regs
    import spid_ack_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       s_wr;
    logic [2:0] s_idx;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite;
    assign s_idx  = paddr[CFG_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= RST_GAIN_P;
            r_cfg.gain_i     <= RST_GAIN_I;
            r_cfg.gain_d     <= RST_GAIN_D;
            r_cfg.wheel_base <= RST_WHEEL_BASE;
            r_cfg.period_dt  <= RST_PERIOD_DT;
            r_cfg.rate_hz    <= RST_RATE_HZ;
        end else if (s_wr) begin
            case (s_idx)
                REG_GAIN_P:     r_cfg.gain_p     <= pwdata[15:0];
                REG_GAIN_I:     r_cfg.gain_i     <= pwdata[15:0];
                REG_GAIN_D:     r_cfg.gain_d     <= pwdata[15:0];
                REG_WHEEL_BASE: r_cfg.wheel_base <= pwdata[11:0];
                REG_PERIOD_DT:  r_cfg.period_dt  <= pwdata[15:0];
                REG_RATE_HZ:    r_cfg.rate_hz    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_GAIN_P:     prdata = CFG_DW'(r_cfg.gain_p);
            REG_GAIN_I:     prdata = CFG_DW'(r_cfg.gain_i);
            REG_GAIN_D:     prdata = CFG_DW'(r_cfg.gain_d);
            REG_WHEEL_BASE: prdata = CFG_DW'(r_cfg.wheel_base);
            REG_PERIOD_DT:  prdata = CFG_DW'(r_cfg.period_dt);
            REG_RATE_HZ:    prdata = CFG_DW'(r_cfg.rate_hz);
            default:        prdata = '0;
        endcase
    end

endmodule

### rtl/spid_ack_ctrl.sv
module spid_ack_ctrl
    import spid_ack_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                // one product per cycle, consumed by the datapath in the cycle after
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = t_mul_op'(r_cnt[MOP_W-1:0]);
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_CINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt             = '0;
                n_state           = ST_CORDIC;
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.step_idx    = r_cnt;
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_MUL) && (r_cnt == '0))
        else $error("load did not start the multiply sequence");
    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORDIC) |-> (r_cnt < STEP_W'(CORDIC_STEPS)))
        else $error("cordic counter past last iteration");
    a_finish_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_in_ready)
        else $error("not ready for a request after finishing");
`endif

endmodule

### rtl/spid_ack_dp.sv
module spid_ack_dp
    import spid_ack_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_cs,
    input  logic signed [15:0] i_yaw,
    input  logic signed [15:0] i_ms,
    input  logic               i_out_ready,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic signed [15:0] o_drive,
    output logic signed [15:0] o_steer,
    output logic               o_sat
);

    // loop state
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [INT_W-1:0]  r_integ;

    // per-request working registers
    logic signed [ERR_W-1:0]  r_e;
    logic signed [DIF_W-1:0]  r_d18;
    logic signed [15:0]       r_cs;
    logic signed [15:0]       r_yaw;
    logic                     r_steer_zero;
    logic signed [DRV_W-1:0]  r_y28;
    logic signed [DRV_W-1:0]  r_d28;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;
    logic signed [PROD_W-1:0] r_prod;
    t_mul_op                  r_prod_op;
    logic                     r_prod_vld;
    logic signed [CRD_W-1:0]  r_x;
    logic signed [CRD_W-1:0]  r_y;
    logic signed [Z_W-1:0]    r_z;

    logic                     r_out_valid;
    logic signed [15:0]       r_drive;
    logic signed [15:0]       r_steer;
    logic                     r_sat_out;

    logic signed [ERR_W-1:0]  s_e;
    logic signed [MULA_W-1:0] s_mul_a;
    logic signed [MULB_W-1:0] s_mul_b;
    logic signed [PROD_W-1:0] s_mul_p;
    logic signed [INT_W:0]    s_isum;
    logic                     s_iclip;
    logic signed [INT_W-1:0]  s_integ_sat;
    logic signed [ACC_W-1:0]  s_acc_base;
    logic signed [ACC_W-1:0]  s_addend;
    logic signed [ACC_W-1:0]  s_acc_sum;
    logic signed [CRD_W-1:0]  s_xi;
    logic signed [CRD_W-1:0]  s_yi;
    logic signed [CRD_W-1:0]  s_xs;
    logic signed [CRD_W-1:0]  s_ys;
    logic signed [Z_W-1:0]    s_dz;
    logic                     s_fit;
    logic signed [15:0]       s_drive;
    logic signed [Z_W+2:0]    s_t;
    logic signed [15:0]       s_steer;

    assign s_e = ERR_W'(i_cs) - ERR_W'(i_ms);

    // shared multiplier operand select
    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        case (i_cmd.mul_op)
            MUL_WB: begin
                s_mul_a = MULA_W'(r_yaw);
                s_mul_b = MULB_W'({1'b0, i_cfg.wheel_base});
            end
            MUL_EDT: begin
                s_mul_a = MULA_W'(r_e);
                s_mul_b = MULB_W'({1'b0, i_cfg.period_dt});
            end
            MUL_DRATE: begin
                s_mul_a = MULA_W'(r_d18);
                s_mul_b = MULB_W'({1'b0, i_cfg.rate_hz});
            end
            MUL_GP: begin
                s_mul_a = MULA_W'(r_e);
                s_mul_b = MULB_W'({1'b0, i_cfg.gain_p});
            end
            MUL_GILO: begin
                s_mul_a = MULA_W'({1'b0, r_integ[23:0]});
                s_mul_b = MULB_W'({1'b0, i_cfg.gain_i});
            end
            MUL_GIHI: begin
                s_mul_a = MULA_W'($signed(r_integ[INT_W-1:24]));
                s_mul_b = MULB_W'({1'b0, i_cfg.gain_i});
            end
            MUL_GD: begin
                s_mul_a = MULA_W'(r_d28);
                s_mul_b = MULB_W'({1'b0, i_cfg.gain_d});
            end
            default: ;
        endcase
    end

    assign s_mul_p = s_mul_a * s_mul_b;

    // integral update with clipping
    assign s_isum      = (INT_W+1)'(r_integ) + (INT_W+1)'(r_prod);
    assign s_iclip     = s_isum[INT_W] != s_isum[INT_W-1];
    assign s_integ_sat = s_iclip ? (s_isum[INT_W] ? INTEG_MIN : INTEG_MAX)
                                 : s_isum[INT_W-1:0];

    // PID sum in Q.36; the gain_p term seeds the rounding offset
    always_comb begin
        s_acc_base = r_acc;
        s_addend   = '0;
        case (r_prod_op)
            MUL_GP: begin
                s_acc_base = ACC_RND;
                s_addend   = ACC_W'(r_prod) <<< 16;
            end
            MUL_GILO: s_addend = ACC_W'(r_prod);
            MUL_GIHI: s_addend = ACC_W'(r_prod) <<< 24;
            MUL_GD:   s_addend = ACC_W'(r_prod) <<< 16;
            default: ;
        endcase
    end

    assign s_acc_sum = s_acc_base + s_addend;

    // cordic, vectoring toward y = 0, right half plane
    assign s_xi = r_cs[15] ? -(CRD_W'(r_cs) <<< 11) : (CRD_W'(r_cs) <<< 11);
    assign s_yi = r_cs[15] ? -CRD_W'(r_y28) : CRD_W'(r_y28);
    assign s_xs = r_x >>> i_cmd.step_idx;
    assign s_ys = r_y >>> i_cmd.step_idx;
    assign s_dz = Z_W'({1'b0, atan_q16(i_cmd.step_idx)});

    // drive: Q.36 to Q.8 with saturation
    assign s_fit   = (&r_acc[ACC_W-1:43]) | ~(|r_acc[ACC_W-1:43]);
    assign s_drive = s_fit ? r_acc[43:28] : (r_acc[ACC_W-1] ? 16'sh8000 : 16'sh7fff);

    // steering: floor((16 - 3*z) / 32)
    assign s_t     = (Z_W+3)'(16) - ((Z_W+3)'(r_z) + ((Z_W+3)'(r_z) <<< 1));
    assign s_steer = r_steer_zero ? 16'sd0 : 16'(s_t >>> 5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_integ     <= '0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.load) begin
                r_prev <= s_e;
            end
            if (r_prod_vld && (r_prod_op == MUL_EDT)) begin
                r_integ <= s_integ_sat;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e          <= s_e;
            r_d18        <= DIF_W'(s_e) - DIF_W'(r_prev);
            r_cs         <= i_cs;
            r_yaw        <= i_yaw;
            r_steer_zero <= (i_cs == 16'sd0) || (i_yaw == 16'sd0);
            r_sat        <= 1'b0;
        end else if (r_prod_vld && (r_prod_op == MUL_EDT) && s_iclip) begin
            r_sat <= 1'b1;
        end
        if (i_cmd.mul_en) begin
            r_prod    <= s_mul_p;
            r_prod_op <= i_cmd.mul_op;
        end
        if (r_prod_vld) begin
            case (r_prod_op)
                MUL_WB:    r_y28 <= r_prod[DRV_W-1:0];
                MUL_DRATE: r_d28 <= r_prod[DRV_W-1:0];
                MUL_GP, MUL_GILO, MUL_GIHI, MUL_GD: r_acc <= s_acc_sum;
                default: ;
            endcase
        end
        if (i_cmd.cordic_init) begin
            r_x <= s_xi;
            r_y <= s_yi;
            r_z <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_y[CRD_W-1]) begin
                r_x <= r_x + s_ys;
                r_y <= r_y - s_xs;
                r_z <= r_z + s_dz;
            end else begin
                r_x <= r_x - s_ys;
                r_y <= r_y + s_xs;
                r_z <= r_z - s_dz;
            end
        end
        if (i_cmd.finish) begin
            r_drive   <= s_drive;
            r_steer   <= s_steer;
            r_sat_out <= r_sat | ~s_fit;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_drive        = r_drive;
    assign o_steer        = r_steer;
    assign o_sat          = r_sat_out;

`ifndef NO_ASSERTIONS
    a_prod_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_step |-> !r_prod_vld)
        else $error("product still pending during cordic");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_out_valid)
        else $error("finished result not presented");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_steer) && $stable(o_sat)))
        else $error("stalled result changed");
`endif

endmodule

### bench/spid_ack_scoreboard_pkg.sv
`timescale 1ns / 1ps

package spid_ack_scoreboard_pkg;
    import spid_ack_pkg::*;

    localparam int CORDIC_ITERS = 14;
    localparam int ATAN_ENTRIES = 20;

    localparam longint INTEG_TOP    = 64'sd549755813887;
    localparam longint INTEG_BOTTOM = -INTEG_TOP - 64'sd1;

    typedef struct {
        logic signed [15:0] drive_command;
        logic signed [15:0] steering_command;
        logic               drive_saturated;
    } t_drive_steer;

    class drive_steer_scoreboard;
        longint gain_p, gain_i, gain_d, wheel_base, period_dt, rate_hz;
        longint prev_error;
        longint error_integral;
        t_drive_steer expected_q[$];
        int mismatches;

        function new();
            gain_p         = longint'(RST_GAIN_P);
            gain_i         = longint'(RST_GAIN_I);
            gain_d         = longint'(RST_GAIN_D);
            wheel_base     = longint'(RST_WHEEL_BASE);
            period_dt      = longint'(RST_PERIOD_DT);
            rate_hz        = longint'(RST_RATE_HZ);
            prev_error     = 0;
            error_integral = 0;
            mismatches     = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_GAIN_P:     gain_p     = longint'(value[15:0]);
                REG_GAIN_I:     gain_i     = longint'(value[15:0]);
                REG_GAIN_D:     gain_d     = longint'(value[15:0]);
                REG_WHEEL_BASE: wheel_base = longint'(value[11:0]);
                REG_PERIOD_DT:  period_dt  = longint'(value[15:0]);
                REG_RATE_HZ:    rate_hz    = longint'(value[9:0]);
                default: ;
            endcase
        endfunction

        // atan(2^-i) in Q.16
        function longint atan_step(input int i);
            case (i)
                0:  return 51472;
                1:  return 30385;
                2:  return 16055;
                3:  return 8150;
                4:  return 4091;
                5:  return 2047;
                6:  return 1024;
                7:  return 512;
                8:  return 256;
                9:  return 128;
                10: return 64;
                11: return 32;
                12: return 16;
                13: return 8;
                14: return 4;
                15: return 2;
                16: return 1;
                default: return 0;
            endcase
        endfunction

        // vectoring rotation on (speed, wheelbase*yaw), both Q.19; angle in Q.16
        function longint steer_angle(input longint speed, input longint yaw);
            longint x, y, z, xs, ys;
            x = speed * 2048;
            y = wheel_base * yaw;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_ITERS && i < ATAN_ENTRIES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += atan_step(i);
                end else begin
                    x -= ys;
                    y += xs;
                    z -= atan_step(i);
                end
            end
            return z;
        endfunction

        function void note_request(input logic signed [15:0] cs, input logic signed [15:0] yaw,
                                   input logic signed [15:0] ms);
            longint err, deriv, acc, drive, steer;
            bit clipped;
            t_drive_steer r;
            clipped = 1'b0;
            err = longint'(cs) - longint'(ms);

            error_integral += err * period_dt;
            if (error_integral > INTEG_TOP) begin
                error_integral = INTEG_TOP;
                clipped = 1'b1;
            end else if (error_integral < INTEG_BOTTOM) begin
                error_integral = INTEG_BOTTOM;
                clipped = 1'b1;
            end

            deriv = (err - prev_error) * rate_hz;
            prev_error = err;

            // Q.36 sum, round half up to Q.8
            acc = gain_p * err * 65536 + gain_i * error_integral + gain_d * deriv * 65536;
            drive = (acc + 64'sd134217728) >>> 28;
            if (drive > 32767) begin
                drive = 32767;
                clipped = 1'b1;
            end else if (drive < -32768) begin
                drive = -32768;
                clipped = 1'b1;
            end

            if (cs == 0 || yaw == 0)
                steer = 0;
            else
                steer = (-3 * steer_angle(longint'(cs), longint'(yaw)) + 16) >>> 5;

            r.drive_command    = drive[15:0];
            r.steering_command = steer[15:0];
            r.drive_saturated  = clipped;
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic signed [15:0] drive,
                                   input logic signed [15:0] steer, input logic sat);
            t_drive_steer want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: drive_command %0d steering_command %0d sat %0b",
                       drive, steer, sat);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (drive !== want.drive_command) begin
                $error("drive_command: expected %0d, got %0d", want.drive_command, drive);
                mismatches++;
            end
            if (steer !== want.steering_command) begin
                $error("steering_command: expected %0d, got %0d",
                       want.steering_command, steer);
                mismatches++;
            end
            if (sat !== want.drive_saturated) begin
                $error("drive_saturated: expected %0b, got %0b", want.drive_saturated, sat);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

### bench/speed_pid_with_ackermann_steering_top_test.sv
`timescale 1ns / 1ps

module speed_pid_with_ackermann_steering_top_test;
    import spid_ack_pkg::*;
    import spid_ack_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    spid_ack_in_if  cmd_if ();
    spid_ack_out_if res_if ();

    speed_pid_with_ackermann_steering_top #(
        .CORDIC_STEPS(CORDIC_ITERS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    drive_steer_scoreboard sb;
    int                    quiet_cycles = 0;
    int                    burst_left = 0;
    int unsigned           rx_cycle = 0;
    logic [15:0]           stall_mask = 16'hFFFF;
    logic signed [15:0]    last_cs = '0;
    logic signed [15:0]    last_yaw = '0;
    logic signed [15:0]    last_ms = '0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready)
            sb.note_request(cmd_if.commanded_speed, cmd_if.commanded_yaw_rate,
                            cmd_if.measured_speed);
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.drive_command, res_if.steering_command,
                            res_if.drive_saturated);
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure: ready follows a 16-bit mask, reshuffled whenever rx_cycle[6:0] is zero
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[6:0] == 7'd0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask <= 16'hFFFF;
                1:       stall_mask <= 16'($urandom & $urandom) | 16'h0001;
                default: stall_mask <= 16'($urandom) | 16'h0001;
            endcase
        end
        res_if.ready <= stall_mask[rx_cycle[3:0]];
    end

    task automatic send_request(input logic signed [15:0] cs, input logic signed [15:0] yaw,
                                input logic signed [15:0] ms);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        cmd_if.valid              <= 1'b1;
        cmd_if.commanded_speed    <= cs;
        cmd_if.commanded_yaw_rate <= yaw;
        cmd_if.measured_speed     <= ms;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_random_request();
        int                 kind;
        int                 base;
        logic signed [15:0] cs, yaw, ms;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            cs  = 16'($urandom);
            yaw = 16'($urandom);
            ms  = 16'($urandom);
        end else if (kind < 60) begin
            // speed loop tracking its set point
            base = int'($urandom_range(0, 8000)) - 4000;
            cs   = 16'(base);
            ms   = 16'(base + int'($urandom_range(0, 64)) - 32);
            yaw  = 16'(int'($urandom_range(0, 4096)) - 2048);
        end else if (kind < 70) begin
            cs  = ($urandom_range(0, 1) == 0) ? 16'sd0 : 16'($urandom);
            yaw = (cs != 0) ? 16'sd0 : 16'($urandom);
            ms  = 16'($urandom);
        end else if (kind < 80) begin
            cs  = corner_value();
            yaw = corner_value();
            ms  = corner_value();
        end else begin
            cs  = last_cs;
            yaw = last_yaw;
            ms  = last_ms;
        end
        last_cs  = cs;
        last_yaw = yaw;
        last_ms  = ms;
        send_request(cs, yaw, ms);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [31:0] gp, input logic [31:0] gi,
                                input logic [31:0] gd, input logic [31:0] wb,
                                input logic [31:0] dt, input logic [31:0] rate);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_WHEEL_BASE, wb);
        write_reg(REG_PERIOD_DT, dt);
        write_reg(REG_RATE_HZ, rate);
    endtask

    task automatic write_random_config();
        logic [31:0] gp, gi, gd, dt;
        gp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12288);
        gi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
        gd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2048);
        dt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
        write_config(gp, gi, gd, $urandom_range(0, 4095), dt, $urandom_range(1, 1000));
    endtask

    initial begin
        int pause_at;
        sb = new();
        i_rst_n                   = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        cmd_if.valid              = 1'b0;
        cmd_if.commanded_speed    = '0;
        cmd_if.commanded_yaw_rate = '0;
        cmd_if.measured_speed     = '0;
        res_if.ready              = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: field corners, all four steering quadrants, zero speed / yaw
        send_request(16'sd0, 16'sd0, 16'sd0);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_request(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_request(16'sd0, 16'sd1000, 16'sd0);
        send_request(16'sd1000, 16'sd0, 16'sd0);
        send_request(16'sd256, 16'sd2048, 16'sd0);
        send_request(-16'sd256, 16'sd2048, 16'sd0);
        send_request(16'sd256, -16'sd2048, 16'sd0);
        send_request(-16'sd256, -16'sd2048, 16'sd0);
        send_request(16'sd1, 16'sh7FFF, 16'sd0);
        send_request(-16'sd1, 16'sh8000, 16'sd0);
        send_request(16'sh7FFF, 16'sd1, 16'sh7FFF);
        send_request(16'sh8000, 16'sd1, 16'sh8000);
        send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_request(-16'sd1, -16'sd1, -16'sd1);
        send_request(16'sd100, 16'sd500, 16'sd120);
        send_request(16'sd100, 16'sd500, 16'sd120);
        send_request(16'sd0, 16'sd0, 16'sh7FFF);
        send_request(16'sd0, 16'sd0, 16'sh8000);
        wait_results_drained();

        write_config(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFF, 32'hFFFF, 32'd1000);
        repeat (100) send_random_request();
        wait_results_drained();

        // integral alone reaches the drive: wind it to the top clip, then to the bottom
        write_config(32'd0, 32'd1, 32'd0, 32'd768, 32'hFFFF, 32'd1000);
        repeat (140) send_request(16'sh7FFF, 16'($urandom), 16'sh8000);
        repeat (270) send_request(16'sh8000, 16'($urandom), 16'sh7FFF);
        wait_results_drained();

        write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        repeat (60) send_random_request();
        wait_results_drained();

        for (int phase = 0; phase < 6; phase++) begin
            write_random_config();
            pause_at = $urandom_range(20, 160);
            for (int n = 0; n < 185; n++) begin
                if (n == pause_at)
                    wait_results_drained();
                send_random_request();
            end
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
rtl/spid_ack_pkg.sv
rtl/spid_ack_if.sv
rtl/spid_ack_regs.sv
rtl/spid_ack_ctrl.sv
rtl/spid_ack_dp.sv
rtl/speed_pid_with_ackermann_steering_top.sv
bench/spid_ack_scoreboard_pkg.sv
bench/speed_pid_with_ackermann_steering_top_test.sv
